// ----- src/bitmap_block_allocator_defines.svh -----
// assertion macros for the bitmap block allocator
// no dependencies; included by the module that carries assertions
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define BBA_ASSERT_IMP(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define BBA_ASSERT_NXT(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define BBA_ASSERT_IMP(lbl, clk, rst, a, c, msg)
`define BBA_ASSERT_NXT(lbl, clk, rst, a, c, msg)
`endif

`endif

// ----- src/bba_pkg.sv -----
// constants and types shared by the bitmap block allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int WORD_BITS  = 32;
  localparam int NUM_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W       = $clog2(NUM_WORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int DATA_W     = 16;

  localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(1024);

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_TEST  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_CLEAR = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ----- src/bba_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/bitmap_block_allocator.sv -----
// bitmap block allocator top level, first-fit search over a usage bitmap in ram
// depends on bba_pkg, bba_ram and bitmap_block_allocator_defines.svh
//
// input channel s_*: s_tuser carries the operation (allocate, free, test),
// s_tdata the block index. output channel m_*: m_tuser carries the status,
// m_tdata the result index and the test bit. one result item per input item.
// cfg_wen/cfg_wdata set the block count; write it only while the block is idle.
// the bitmap lives in a 32 x 32 ram; a per-word valid flag makes words never
// written read as zero, so reset takes effect at once with no clearing pass.
// free and test read the bitmap word in S_LOOK, check the bit in S_CHECK, then
// pass to S_DONE. allocate reads one bitmap word per cycle in order; the first
// free bit in range ends the search, and a full bitmap ends it after the last
// word in range. a count of zero or a bad index or op goes straight to S_DONE
// with no bitmap read. one item is worked on at a time; s_tready is high only
// when no item is open and rises the cycle after a result is loaded. if m_tready
// is low the next result waits in the block, which then holds s_tready low. rst
// is synchronous and active high; it empties the bitmap and restores a block
// count of 1024.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_block_allocator_defines.svh"

module bitmap_block_allocator
  import bba_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wen,
  input  wire logic [CNT_W-1:0]  cfg_wdata,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [DATA_W-1:0] s_tdata,   // block_index[9:0], zero pad
  input  wire logic [1:0]        s_tuser,   // op[1:0]
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [DATA_W-1:0]      m_tdata,   // result_index[9:0], bit_value[10], zero pad
  output logic [1:0]             m_tuser    // status[1:0]
);

  state_t               state;
  logic [CNT_W-1:0]     total_blocks;
  logic [CNT_W-1:0]     limit;
  logic [1:0]           op_q;
  logic [IDX_W-1:0]     idx_q;
  logic [IDX_W-1:0]     lim_m1;
  logic [WA_W-1:0]      ptr;
  logic [WA_W-1:0]      chk_addr;
  logic                 chk_valid;
  logic [NUM_WORDS-1:0] word_valid;

  logic [IDX_W-1:0]     pend_idx;
  status_t              pend_status;
  logic                 pend_bit;
  logic [IDX_W-1:0]     res_idx;
  status_t              res_status;
  logic                 res_bit;

  logic                 mem_we;
  logic [WA_W-1:0]      mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [WA_W-1:0]      mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  logic [WORD_BITS-1:0] word_eff;
  logic [WORD_BITS-1:0] range_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] lowest;
  logic [BIT_W-1:0]     enc;
  logic [IDX_W-1:0]     alloc_idx;
  logic                 found_scan;
  logic                 bit_set;
  logic [WA_W-1:0]      last_w;
  logic                 accept;
  logic                 out_free;
  logic                 load_out;

  bba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(NUM_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign limit    = (total_blocks > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total_blocks;
  assign last_w   = lim_m1[IDX_W-1:BIT_W];
  assign s_tready = (state == S_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign load_out = (state == S_DONE) && out_free;
  assign alloc_idx = {chk_addr, enc};
  assign m_tdata  = {{(DATA_W-IDX_W-1){1'b0}}, res_bit, res_idx};
  assign m_tuser  = res_status;

  always_comb begin
    word_eff = word_valid[chk_addr] ? mem_rdata : '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      range_mask[b] = (chk_addr != last_w) || (BIT_W'(b) <= lim_m1[BIT_W-1:0]);
    end
    free_bits = ~word_eff & range_mask;
    lowest    = free_bits & (~free_bits + WORD_BITS'(1));
    enc       = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (lowest[b]) begin
        enc = enc | BIT_W'(b);
      end
    end
    found_scan = (state == S_SCAN) && chk_valid && (|free_bits);
    bit_set    = word_eff[idx_q[BIT_W-1:0]];

    mem_re    = (state == S_SCAN) || (state == S_LOOK);
    mem_raddr = (state == S_SCAN) ? ptr : idx_q[IDX_W-1:BIT_W];
    mem_waddr = chk_addr;
    mem_we    = found_scan || ((state == S_CHECK) && (op_q == OP_FREE) && bit_set);
    mem_wdata = found_scan ? (word_eff | lowest)
                           : (word_eff & ~(WORD_BITS'(1) << idx_q[BIT_W-1:0]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      total_blocks <= TOTAL_RESET;
      m_tvalid     <= 1'b0;
      word_valid   <= '0;
      chk_valid    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        total_blocks <= cfg_wdata;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (mem_we) begin
        word_valid[chk_addr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_q      <= s_tuser;
            idx_q     <= s_tdata[IDX_W-1:0];
            lim_m1    <= IDX_W'(limit - CNT_W'(1));
            chk_valid <= 1'b0;
            ptr       <= '0;
            pend_bit  <= 1'b0;
            if (s_tuser == OP_ALLOC) begin
              if (limit == '0) begin
                pend_idx    <= '0;
                pend_status <= ST_FULL;
                state       <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end else if (((s_tuser == OP_FREE) || (s_tuser == OP_TEST)) &&
                         ({1'b0, s_tdata[IDX_W-1:0]} < limit)) begin
              state <= S_LOOK;
            end else begin
              pend_idx    <= s_tdata[IDX_W-1:0];
              pend_status <= ST_RANGE;
              state       <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          ptr       <= ptr + WA_W'(1);
          chk_valid <= 1'b1;
          chk_addr  <= ptr;
          if (found_scan) begin
            pend_idx    <= alloc_idx;
            pend_status <= ST_OK;
            state       <= S_DONE;
          end else if (chk_valid && (chk_addr == last_w)) begin
            pend_idx    <= '0;
            pend_status <= ST_FULL;
            state       <= S_DONE;
          end
        end
        S_LOOK: begin
          chk_addr <= idx_q[IDX_W-1:BIT_W];
          state    <= S_CHECK;
        end
        S_CHECK: begin
          pend_idx <= idx_q;
          if (op_q == OP_FREE) begin
            pend_status <= bit_set ? ST_OK : ST_CLEAR;
            pend_bit    <= 1'b0;
          end else begin
            pend_status <= ST_OK;
            pend_bit    <= bit_set;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            res_idx    <= pend_idx;
            res_status <= pend_status;
            res_bit    <= pend_bit;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BBA_ASSERT_IMP(a_we_state, clk, rst, mem_we, (state == S_SCAN) || (state == S_CHECK), "stray write")
  `BBA_ASSERT_IMP(a_alloc_range, clk, rst, found_scan, alloc_idx <= lim_m1, "index beyond count")
  `BBA_ASSERT_IMP(a_alloc_clear, clk, rst, found_scan, !word_eff[enc], "block already in use")
  `BBA_ASSERT_NXT(a_accept_busy, clk, rst, accept, state != S_IDLE, "idle after accept")

endmodule

`default_nettype wire

// ----- test/bba_result_checker.sv -----
// result checker for the bitmap block allocator: keeps its own usage map and block count,
// predicts one answer per accepted request and compares it with each accepted result
// depends on bba_pkg
`timescale 1ns / 1ps

module bba_result_checker
  import bba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // block_index[9:0], zero pad
  input  logic [1:0]        s_tuser,   // op[1:0]
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [DATA_W-1:0] m_tdata,   // result_index[9:0], bit_value[10], zero pad
  input  logic [1:0]        m_tuser,   // status[1:0]
  output int                fail_count,
  output int                pending,
  output int                full_seen,
  output int                clear_seen,
  output int                range_seen
);

  typedef struct packed {
    logic [IDX_W-1:0] index;
    status_t          status;
    logic             in_use;
  } answer_t;

  logic [MAX_BLOCKS-1:0] usage_map;
  logic [CNT_W-1:0]      block_count;
  answer_t               answers_due[$];

  initial begin
    fail_count = 0;
    pending = 0;
    full_seen = 0;
    clear_seen = 0;
    range_seen = 0;
    usage_map = '0;
    block_count = TOTAL_RESET;
  end

  // first-fit allocate, free and test against the local usage map
  function automatic answer_t allocator_answer(input logic [1:0] op,
                                               input logic [IDX_W-1:0] idx);
    int limit;
    answer_t ans;
    limit = (int'(block_count) > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_count);
    ans.index = idx;
    ans.status = ST_OK;
    ans.in_use = 1'b0;
    case (op)
      OP_ALLOC: begin
        ans.index = '0;
        ans.status = ST_FULL;
        for (int i = 0; i < limit && ans.status == ST_FULL; i++) begin
          if (!usage_map[i]) begin
            usage_map[i] = 1'b1;
            ans.index = IDX_W'(i);
            ans.status = ST_OK;
          end
        end
      end
      OP_FREE: begin
        if (int'(idx) >= limit) ans.status = ST_RANGE;
        else if (!usage_map[idx]) ans.status = ST_CLEAR;
        else usage_map[idx] = 1'b0;
      end
      OP_TEST: begin
        if (int'(idx) >= limit) ans.status = ST_RANGE;
        else ans.in_use = usage_map[idx];
      end
      default: ans.status = ST_RANGE;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    answer_t got;
    answer_t due;
    if (rst) begin
      usage_map = '0;
      block_count = TOTAL_RESET;
      answers_due.delete();
      pending = 0;
    end else begin
      if (cfg_wen) block_count = cfg_wdata;
      if (m_tvalid && m_tready) begin
        got.index = m_tdata[IDX_W-1:0];
        got.in_use = m_tdata[IDX_W];
        got.status = status_t'(m_tuser);
        if (answers_due.size() == 0) begin
          $display("%0t ns: result with nothing expected, index %0d status %0d bit %0d",
                   $time, got.index, got.status, got.in_use);
          fail_count++;
        end else begin
          due = answers_due.pop_front();
          if (got.index !== due.index) begin
            $display("%0t ns: result_index expected %0d, got %0d", $time, due.index, got.index);
            fail_count++;
          end
          if (got.status !== due.status) begin
            $display("%0t ns: status expected %0d, got %0d", $time, due.status, got.status);
            fail_count++;
          end
          if (got.in_use !== due.in_use) begin
            $display("%0t ns: bit_value expected %0d, got %0d", $time, due.in_use, got.in_use);
            fail_count++;
          end
          case (due.status)
            ST_FULL:  full_seen++;
            ST_CLEAR: clear_seen++;
            ST_RANGE: range_seen++;
            default: ;
          endcase
        end
      end
      if (s_tvalid && s_tready)
        answers_due.push_back(allocator_answer(s_tuser, s_tdata[IDX_W-1:0]));
      pending = answers_due.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
// top of the bitmap block allocator test: clock, reset, request stimulus, result stalls,
// block-count writes and the verdict
// depends on bba_pkg, bitmap_block_allocator and bba_result_checker
`timescale 1ns / 1ps

module testbench;
  import bba_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int MAX_GAP = 11;
  localparam int IDLE_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 40;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wen = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;   // block_index[9:0], zero pad
  logic [1:0]        s_tuser = OP_ALLOC;   // op[1:0]
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;   // result_index[9:0], bit_value[10], zero pad
  logic [1:0]        m_tuser;   // status[1:0]

  logic quiet = 1'b0;
  logic result_taken = 1'b0;
  int   ready_hold = 0;
  int   idle_cycles = 0;
  int   requests_sent = 0;
  int   settings_used = 0;
  int   fails, pending, full_seen, clear_seen, range_seen;

  bitmap_block_allocator uut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  bba_result_checker u_check (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fails), .pending(pending), .full_seen(full_seen),
    .clear_seen(clear_seen), .range_seen(range_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stall drawn after every result item, none in quiet phases
  always @(posedge clk) result_taken <= m_tvalid && m_tready;

  always @(negedge clk) begin : receiver
    int hold_now;
    hold_now = result_taken ? (quiet ? 0 : $urandom_range(0, MAX_GAP)) : ready_hold;
    if (hold_now > 0) begin
      m_tready <= 1'b0;
      ready_hold <= hold_now - 1;
    end else begin
      m_tready <= 1'b1;
      ready_hold <= 0;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] idx);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= DATA_W'(idx);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_count(input logic [CNT_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] count, input int items, input int alloc_pct);
    int limit;
    int top_idx;
    int r;
    logic [1:0] op;
    logic [IDX_W-1:0] idx;
    set_count(count);
    quiet = ($urandom_range(0, 3) == 0);
    limit = (int'(count) > MAX_BLOCKS) ? MAX_BLOCKS : int'(count);
    top_idx = (limit + 3 > MAX_BLOCKS - 1) ? MAX_BLOCKS - 1 : limit + 3;
    repeat (items) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct) begin
        op = OP_ALLOC;
      end else begin
        r = $urandom_range(0, 19);
        op = (r < 10) ? OP_FREE : ((r < 19) ? OP_TEST : OP_NONE);
      end
      idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, top_idx));
      if ($urandom_range(0, 99) == 0) drain();
      send_item(op, idx);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty map at full count
    send_item(OP_TEST, 10'd0);
    send_item(OP_FREE, 10'd0);
    send_item(OP_ALLOC, 10'd1023);
    send_item(OP_ALLOC, 10'd0);
    send_item(OP_ALLOC, 10'd512);
    send_item(OP_TEST, 10'd1);
    send_item(OP_FREE, 10'd1);
    send_item(OP_TEST, 10'd1);
    send_item(OP_ALLOC, 10'd0);
    send_item(OP_TEST, 10'd1023);
    send_item(OP_FREE, 10'd1023);
    send_item(OP_NONE, 10'd1023);
    send_item(OP_NONE, 10'd0);
    // zero count
    set_count(11'd0);
    send_item(OP_ALLOC, 10'd0);
    send_item(OP_FREE, 10'd0);
    send_item(OP_TEST, 10'd1023);
    // count above the block total
    set_count(11'd2047);
    send_item(OP_TEST, 10'd1023);
    send_item(OP_ALLOC, 10'd0);
    // single block, already taken
    set_count(11'd1);
    send_item(OP_ALLOC, 10'd0);
    send_item(OP_TEST, 10'd0);
    send_item(OP_FREE, 10'd1);
    set_count(11'd5);
    send_item(OP_ALLOC, 10'd0);
    send_item(OP_ALLOC, 10'd0);
    send_item(OP_FREE, 10'd4);
    send_item(OP_TEST, 10'd4);

    run_phase(11'd1, 80, 40);
    run_phase(11'd7, 85, 50);
    run_phase(11'd33, 85, 55);
    run_phase(11'd2, 60, 45);
    // fill the whole map, then keep asking
    run_phase(11'd2047, 1060, 98);
    run_phase(11'd64, 80, 30);
    run_phase(11'd0, 40, 30);
    run_phase(CNT_W'($urandom_range(1, 2047)), 90, 50);
    run_phase(11'd1024, 90, 50);
    run_phase(11'd1000, 90, 60);

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("sent %0d requests under %0d block-count settings from 0 up to past the total",
             requests_sent, settings_used);
    $display("answers checked include %0d no-free, %0d already-clear, %0d out-of-range",
             full_seen, clear_seen, range_seen);
    if (fails == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
